// File: hw/rtl/wg26_pkg.sv
package wg26_pkg;

  localparam int unsigned TickW = 16;
  localparam int unsigned CodeW = 24;
  localparam int unsigned FrameBits = 26;
  localparam int unsigned BitsW = 5;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [TickW-1:0] PulseReset = 16'd100;
  localparam logic [TickW-1:0] PeriodReset = 16'd1000;
  localparam logic [BitsW-1:0] FrameBitsCnt = 5'd26;

  localparam logic RegPulse = 1'b0;
  localparam logic RegPeriod = 1'b1;

  localparam logic ReqTick = 1'b0;
  localparam logic ReqLoad = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [CodeW-1:0] card_code;
  } in_beat_t;

  typedef struct packed {
    logic data_level;
    logic strobe_level;
    logic busy_res;
    logic load_rejected;
    logic frame_done;
  } out_beat_t;

  typedef struct packed {
    logic [TickW-1:0] pulse_ticks;
    logic [TickW-1:0] period_ticks;
  } cfg_t;

endpackage

// File: hw/rtl/wiegand26_frame_transmitter.sv
// Each input beat is either one timer tick or a card-code load, and the block takes one beat
// per clock cycle whenever the result side keeps up. A beat is captured in an input register,
// advances the frame state once the output register can take its result, and that result
// beat then sits in the output register; the input register frees as soon as the output
// register can take the next result, so ticks stream back to back.
module wiegand26_frame_transmitter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  wg26_pkg::in_beat_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output wg26_pkg::out_beat_t         out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wg26_pkg::AddrW-1:0]  paddr,
  input  logic [wg26_pkg::DataW-1:0]  pwdata,
  output logic [wg26_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  wg26_pkg::cfg_t      cfg;
  wg26_pkg::in_beat_t  in_q;
  wg26_pkg::out_beat_t result;
  wg26_pkg::out_beat_t out_q;
  logic                in_valid_q;
  logic                out_valid_q;
  logic                advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  wg26_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wg26_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .beat_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_done |-> !out_data_o.busy_res)
    else $error("frame_done reported while still busy");

  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.load_rejected |-> out_data_o.busy_res)
    else $error("load rejected while idle");

  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.busy_res |-> out_data_o.data_level && out_data_o.strobe_level)
    else $error("lines not idle high while not busy");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");
`endif

endmodule

// File: hw/rtl/wg26_apb_regs.sv
module wg26_apb_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wg26_pkg::AddrW-1:0]       paddr,
  input  logic [wg26_pkg::DataW-1:0]       pwdata,
  output logic [wg26_pkg::DataW-1:0]       prdata,
  output logic                             pready,
  output wg26_pkg::cfg_t                   cfg_o
);

  logic [wg26_pkg::TickW-1:0] pulse_q;
  logic [wg26_pkg::TickW-1:0] period_q;
  logic                       wr_en;
  logic                       reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q  <= wg26_pkg::PulseReset;
      period_q <= wg26_pkg::PeriodReset;
    end else if (wr_en) begin
      case (reg_sel)
        wg26_pkg::RegPulse:  pulse_q  <= pwdata[wg26_pkg::TickW-1:0];
        wg26_pkg::RegPeriod: period_q <= pwdata[wg26_pkg::TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      wg26_pkg::RegPulse:  prdata[wg26_pkg::TickW-1:0] = pulse_q;
      wg26_pkg::RegPeriod: prdata[wg26_pkg::TickW-1:0] = period_q;
      default:             prdata = '0;
    endcase
  end

  assign cfg_o.pulse_ticks  = pulse_q;
  assign cfg_o.period_ticks = period_q;

endmodule

// File: hw/rtl/wg26_engine.sv
module wg26_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  wg26_pkg::in_beat_t   beat_i,
  input  wg26_pkg::cfg_t       cfg_i,
  output wg26_pkg::out_beat_t  result_o
);

  logic [wg26_pkg::FrameBits-1:0] shift_q, shift_d;
  logic [wg26_pkg::BitsW-1:0]     bits_q, bits_d;
  logic [wg26_pkg::TickW-1:0]     slot_q, slot_d;
  logic                           active_q, active_d;
  logic                           trailing_q, trailing_d;
  logic                           data_q, data_d;

  logic [wg26_pkg::TickW-1:0]     slot_inc;
  logic                           even_p;
  logic                           odd_p;
  logic                           rejected;
  logic                           done;

  assign even_p   = ^beat_i.card_code[23:12];
  assign odd_p    = ~(^beat_i.card_code[11:0]);
  assign slot_inc = slot_q + 16'd1;

  always_comb begin
    shift_d    = shift_q;
    bits_d     = bits_q;
    slot_d     = slot_q;
    active_d   = active_q;
    trailing_d = trailing_q;
    data_d     = data_q;
    rejected   = 1'b0;
    done       = 1'b0;
    if (beat_i.req_type == wg26_pkg::ReqLoad) begin
      if (active_q) begin
        rejected = 1'b1;
      end else begin
        shift_d    = {even_p, beat_i.card_code, odd_p};
        bits_d     = wg26_pkg::FrameBitsCnt;
        slot_d     = '0;
        active_d   = 1'b1;
        trailing_d = 1'b0;
        data_d     = 1'b1;
      end
    end else if (active_q) begin
      slot_d = slot_inc;
      if (slot_inc >= cfg_i.period_ticks || slot_inc == '0) begin
        slot_d = '0;
        if (trailing_q) begin
          active_d   = 1'b0;
          trailing_d = 1'b0;
          bits_d     = '0;
          shift_d    = '0;
          data_d     = 1'b1;
          done       = 1'b1;
        end else begin
          data_d  = shift_q[wg26_pkg::FrameBits-1];
          shift_d = {shift_q[wg26_pkg::FrameBits-2:0], 1'b0};
          if (bits_q != '0) begin
            bits_d = bits_q - 5'd1;
          end
          if (bits_q <= 5'd1) begin
            trailing_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q    <= '0;
      bits_q     <= '0;
      slot_q     <= '0;
      active_q   <= 1'b0;
      trailing_q <= 1'b0;
      data_q     <= 1'b1;
    end else if (step_i) begin
      shift_q    <= shift_d;
      bits_q     <= bits_d;
      slot_q     <= slot_d;
      active_q   <= active_d;
      trailing_q <= trailing_d;
      data_q     <= data_d;
    end
  end

  assign result_o.data_level    = data_d;
  assign result_o.strobe_level  = ~(active_d && (bits_d < wg26_pkg::FrameBitsCnt) &&
                                    (slot_d < cfg_i.pulse_ticks));
  assign result_o.busy_res      = active_d;
  assign result_o.load_rejected = rejected;
  assign result_o.frame_done    = done;

endmodule

// File: tb/tb_wiegand26_frame_transmitter.sv
`timescale 1ns / 1ps
module tb_wiegand26_frame_transmitter;

  localparam int unsigned IdleLimit = 1000;
  localparam logic [wg26_pkg::AddrW-1:0] PulseAddr = {wg26_pkg::RegPulse, 2'b00};
  localparam logic [wg26_pkg::AddrW-1:0] PeriodAddr = {wg26_pkg::RegPeriod, 2'b00};

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  wg26_pkg::in_beat_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  wg26_pkg::out_beat_t out_data_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [wg26_pkg::AddrW-1:0] paddr;
  logic [wg26_pkg::DataW-1:0] pwdata;
  logic [wg26_pkg::DataW-1:0] prdata;
  logic pready;

  logic [wg26_pkg::TickW-1:0] cfg_pulse;
  logic [wg26_pkg::TickW-1:0] cfg_period;
  logic [wg26_pkg::TickW-1:0] slot_cnt;
  logic [wg26_pkg::FrameBits-1:0] frame_bits;
  logic [wg26_pkg::BitsW-1:0] bits_left;
  logic sending;
  logic trailing;
  logic data_bit;

  wg26_pkg::out_beat_t line_states_q[$];
  wg26_pkg::out_beat_t line_want;
  int unsigned errors;
  int unsigned idle_cycles = 0;
  bit steady;

  wiegand26_frame_transmitter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic step_frame(input wg26_pkg::in_beat_t beat, output wg26_pkg::out_beat_t res);
    logic even_par;
    logic odd_par;
    res = '0;
    if (beat.req_type == wg26_pkg::ReqLoad) begin
      if (sending) begin
        res.load_rejected = 1'b1;
      end else begin
        even_par = ^beat.card_code[wg26_pkg::CodeW-1:wg26_pkg::CodeW/2];
        odd_par = ~^beat.card_code[wg26_pkg::CodeW/2-1:0];
        frame_bits = {even_par, beat.card_code, odd_par};
        bits_left = wg26_pkg::FrameBitsCnt;
        slot_cnt = '0;
        sending = 1'b1;
        trailing = 1'b0;
        data_bit = 1'b1;
      end
    end else if (sending) begin
      slot_cnt = slot_cnt + 1'b1;
      if (slot_cnt >= cfg_period || slot_cnt == '0) begin
        slot_cnt = '0;
        if (trailing) begin
          sending = 1'b0;
          trailing = 1'b0;
          bits_left = '0;
          frame_bits = '0;
          data_bit = 1'b1;
          res.frame_done = 1'b1;
        end else begin
          data_bit = frame_bits[wg26_pkg::FrameBits-1];
          frame_bits = frame_bits << 1;
          if (bits_left != '0) begin
            bits_left = bits_left - 1'b1;
          end
          if (bits_left == '0) begin
            trailing = 1'b1;
          end
        end
      end
    end
    res.data_level = data_bit;
    res.strobe_level = !(sending && bits_left < wg26_pkg::FrameBitsCnt && slot_cnt < cfg_pulse);
    res.busy_res = sending;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic wg26_pkg::in_beat_t tick_beat();
    wg26_pkg::in_beat_t beat;
    beat.req_type = wg26_pkg::ReqTick;
    beat.card_code = wg26_pkg::CodeW'($urandom);
    return beat;
  endfunction

  function automatic wg26_pkg::in_beat_t load_beat(input logic [wg26_pkg::CodeW-1:0] code);
    wg26_pkg::in_beat_t beat;
    beat.req_type = wg26_pkg::ReqLoad;
    beat.card_code = code;
    return beat;
  endfunction

  function automatic void check_bit(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s expected %0b actual %0b", name, want, got);
      errors++;
    end
  endfunction

  task automatic send_beat(input wg26_pkg::in_beat_t beat);
    int unsigned gap;
    wg26_pkg::out_beat_t res;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    step_frame(beat, res);
    line_states_q.push_back(res);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (line_states_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [wg26_pkg::AddrW-1:0] addr,
                            input logic [wg26_pkg::TickW-1:0] wdata,
                            output logic [wg26_pkg::DataW-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wg26_pkg::DataW'(wdata);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  task automatic set_timing(input logic [wg26_pkg::TickW-1:0] pulse,
                            input logic [wg26_pkg::TickW-1:0] period);
    logic [wg26_pkg::DataW-1:0] rd;
    drain();
    apb_access(1'b1, PulseAddr, pulse, rd);
    cfg_pulse = pulse;
    apb_access(1'b1, PeriodAddr, period, rd);
    cfg_period = period;
    apb_access(1'b0, PulseAddr, '0, rd);
    if (rd !== wg26_pkg::DataW'(pulse)) begin
      $error("pulse_ticks expected %0d actual %0d", pulse, rd);
      errors++;
    end
    apb_access(1'b0, PeriodAddr, '0, rd);
    if (rd !== wg26_pkg::DataW'(period)) begin
      $error("period_ticks expected %0d actual %0d", period, rd);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_idle_and_reject();
    repeat (3) send_beat(tick_beat());
    send_beat(load_beat('1));
    repeat (4) send_beat(tick_beat());
    send_beat(load_beat('0));
    repeat (2) send_beat(tick_beat());
  endtask

  task automatic test_fast_frame();
    set_timing(16'd1, 16'd1);
    for (int i = 0; sending; i++) begin
      send_beat(i == 10 ? load_beat(wg26_pkg::CodeW'($urandom)) : tick_beat());
    end
    send_beat(tick_beat());
  endtask

  task automatic test_zero_timing();
    set_timing('0, '0);
    send_beat(load_beat(24'hA5A5A5));
    while (sending) send_beat(tick_beat());
  endtask

  task automatic run_phase(input logic [wg26_pkg::TickW-1:0] pulse,
                           input logic [wg26_pkg::TickW-1:0] period,
                           input int unsigned count);
    wg26_pkg::in_beat_t beat;
    set_timing(pulse, period);
    repeat (count) begin
      beat = tick_beat();
      if ($urandom_range(0, 99) < (sending ? 2 : 25)) begin
        beat.req_type = wg26_pkg::ReqLoad;
        case ($urandom_range(0, 7))
          0: beat.card_code = '0;
          1: beat.card_code = '1;
          default: ;
        endcase
      end
      send_beat(beat);
    end
  endtask

  task automatic test_random_frames();
    run_phase(16'd1, 16'd2, 200);
    run_phase(16'd0, 16'd3, 150);
    run_phase(16'd5, 16'd3, 150);
    run_phase(16'd2, 16'd0, 150);
    steady = 1'b1;
    run_phase(16'd1, 16'd1, 150);
    steady = 1'b0;
    run_phase(16'hFFFF, 16'hFFFF, 120);
    run_phase(16'd3, 16'd8, 250);
    repeat (3) begin
      run_phase(wg26_pkg::TickW'($urandom_range(0, 9)),
                wg26_pkg::TickW'($urandom_range(2, 12)), 150);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (line_states_q.size() == 0) begin
        $error("result beat %p arrived with none expected", out_data_o);
        errors++;
      end else begin
        line_want = line_states_q.pop_front();
        check_bit("data_level", line_want.data_level, out_data_o.data_level);
        check_bit("strobe_level", line_want.strobe_level, out_data_o.strobe_level);
        check_bit("busy_res", line_want.busy_res, out_data_o.busy_res);
        check_bit("load_rejected", line_want.load_rejected, out_data_o.load_rejected);
        check_bit("frame_done", line_want.frame_done, out_data_o.frame_done);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned hold;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = pick_gap();
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  initial begin
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    errors = 0;
    steady = 1'b0;
    cfg_pulse = wg26_pkg::PulseReset;
    cfg_period = wg26_pkg::PeriodReset;
    slot_cnt = '0;
    frame_bits = '0;
    bits_left = '0;
    sending = 1'b0;
    trailing = 1'b0;
    data_bit = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_and_reject();
    test_fast_frame();
    test_zero_timing();
    test_random_frames();
    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/wg26_pkg.sv
hw/rtl/wg26_apb_regs.sv
hw/rtl/wg26_engine.sv
hw/rtl/wiegand26_frame_transmitter.sv
tb/tb_wiegand26_frame_transmitter.sv
